[rtl/q4q8_pkg.sv]
// ============================================================================
// q4q8_pkg - shared types and constants
// Request layout, state encoding and numeric constants of the block dot unit.
// ============================================================================
`default_nettype none

package q4q8_pkg;

	localparam int QueueDepth = 2;
	localparam logic [31:0] CanonNan = 32'h7FC0_0000;
	localparam logic [4:0] NibbleBias = 5'd8;

	// One half-precision scale, kept as integer significand times a power of two.
	typedef struct packed {
		logic              sign;
		logic              nan;
		logic              inf;
		logic              zero;
		logic [10:0]       mant;
		logic signed [6:0] expo;
	} half_t;

	// One request as it sits in the queue between front and back.
	typedef struct packed {
		half_t              w;
		half_t              a;
		logic signed [16:0] dot;
		logic               last;
	} blk_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_RND,
		S_ALN,
		S_ADD
	} back_state_t;

endpackage

`default_nettype wire

[rtl/q4q8_front.sv]
// ============================================================================
// q4q8_front - request classification
// Decodes both fp16 scales and forms the exact integer dot of one block pair.
// ============================================================================
`default_nettype none

module q4q8_front (
	input  wire logic [63:0]          weight_bytes_low,
	input  wire logic [63:0]          weight_bytes_high,
	input  wire logic [15:0]          weight_scale,
	input  wire logic [63:0]          act_values_0_7,
	input  wire logic [63:0]          act_values_8_15,
	input  wire logic [63:0]          act_values_16_23,
	input  wire logic [63:0]          act_values_24_31,
	input  wire logic [15:0]          act_scale,
	input  wire logic                 last_block,
	output q4q8_pkg::blk_entry_t      entry
);

	// The value is mant * 2^expo; subnormals are left unnormalised.
	function automatic q4q8_pkg::half_t decode_half(logic [15:0] h);
		q4q8_pkg::half_t r;
		logic [4:0] ex;
		logic [9:0] fr;
		ex = h[14:10];
		fr = h[9:0];
		r.sign = h[15];
		r.nan  = (ex == 5'h1F) && (fr != 10'd0);
		r.inf  = (ex == 5'h1F) && (fr == 10'd0);
		r.zero = (ex == 5'd0) && (fr == 10'd0);
		r.mant = {ex != 5'd0, fr};
		r.expo = (ex == 5'd0) ? -7'sd24 : ($signed({2'b00, ex}) - 7'sd25);
		return r;
	endfunction

	function automatic logic signed [16:0] code_prod(logic [3:0] nib, logic [7:0] act);
		logic signed [4:0] w;
		logic signed [12:0] p;
		w = $signed({1'b0, nib}) - $signed(q4q8_pkg::NibbleBias);
		p = w * $signed(act);
		return 17'(p);
	endfunction

	logic [255:0] acts;
	logic [127:0] codes;
	logic signed [16:0] node [0:62];

	assign acts  = {act_values_24_31, act_values_16_23, act_values_8_15, act_values_0_7};
	assign codes = {weight_bytes_high, weight_bytes_low};

	// Leaves hold the 32 products; inner nodes form a balanced adder tree.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			node[31 + i] = code_prod(codes[8*i +: 4], acts[8*i +: 8]);
			node[47 + i] = code_prod(codes[8*i + 4 +: 4], acts[8*(i + 16) +: 8]);
		end
		for (int k = 30; k >= 0; k--) begin
			node[k] = node[2*k + 1] + node[2*k + 2];
		end
	end

	always_comb begin
		entry.w    = decode_half(weight_scale);
		entry.a    = decode_half(act_scale);
		entry.dot  = node[0];
		entry.last = last_block;
	end

endmodule

`default_nettype wire

[rtl/q4q8_queue.sv]
// ============================================================================
// q4q8_queue - request queue
// Short register queue that lets the front and the back stall independently.
// ============================================================================
`default_nettype none

module q4q8_queue #(
	parameter int Depth = q4q8_pkg::QueueDepth
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire q4q8_pkg::blk_entry_t wdata,
	output logic                      full,
	output logic                      valid,
	output q4q8_pkg::blk_entry_t      rdata,
	input  wire logic                 pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	q4q8_pkg::blk_entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/q4q8_back.sv]
// ============================================================================
// q4q8_back - scaling and accumulation
// Multiplies scales and dot, rounds to binary32 and adds into the accumulator.
// ============================================================================
`default_nettype none

module q4q8_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire q4q8_pkg::blk_entry_t q_data,
	output logic                      q_pop,
	output logic                      dot_valid,
	input  wire logic                 dot_stall,
	output logic [31:0]               dot_result
);

	function automatic logic [5:0] lzc38(logic [37:0] v);
		logic [5:0] r;
		r = 6'd38;
		for (int i = 0; i < 38; i++) begin
			if (v[i]) r = 6'(37 - i);
		end
		return r;
	endfunction

	function automatic logic [4:0] lzc27(logic [26:0] v);
		logic [4:0] r;
		r = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) r = 5'(26 - i);
		end
		return r;
	endfunction

	q4q8_pkg::back_state_t state_q, state_d;
	q4q8_pkg::blk_entry_t ent_q;

	logic [21:0]        pm_q;
	logic [15:0]        mag_q;
	logic [37:0]        p_q;
	logic signed [7:0]  exp_q;
	logic               sign_q;
	logic               tspec_q;
	logic [31:0]        tspec_bits_q;
	logic [31:0]        term_q;
	logic [31:0]        acc_q;
	logic               aln_sx_q, aln_sub_q, aln_spec_q;
	logic [31:0]        aln_spec_bits_q;
	logic [7:0]         aln_ex_q;
	logic [26:0]        aln_mx_q, aln_my_q;
	logic [31:0]        res_q;
	logic               res_valid_q;
	logic               out_free, commit;

	assign out_free   = !res_valid_q || !dot_stall;
	assign dot_valid  = res_valid_q;
	assign dot_result = res_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			q4q8_pkg::S_IDLE: if (q_valid) state_d = q4q8_pkg::S_MUL1;
			q4q8_pkg::S_MUL1: state_d = q4q8_pkg::S_MUL2;
			q4q8_pkg::S_MUL2: state_d = q4q8_pkg::S_RND;
			q4q8_pkg::S_RND:  state_d = q4q8_pkg::S_ALN;
			q4q8_pkg::S_ALN:  state_d = q4q8_pkg::S_ADD;
			q4q8_pkg::S_ADD: begin
				if (!ent_q.last || out_free) begin
					state_d = q_valid ? q4q8_pkg::S_MUL1 : q4q8_pkg::S_IDLE;
				end
			end
			default: state_d = q4q8_pkg::S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		commit = 1'b0;
		q_pop  = 1'b0;
		case (state_q)
			q4q8_pkg::S_IDLE: q_pop = q_valid;
			q4q8_pkg::S_ADD: begin
				commit = !ent_q.last || out_free;
				q_pop  = commit && q_valid;
			end
			default: begin
				commit = 1'b0;
				q_pop  = 1'b0;
			end
		endcase
	end

	// Term special cases and operands.
	logic [16:0] dot_abs;
	logic        t_sign, t_nan, t_inf, t_zero;
	always_comb begin
		dot_abs = ent_q.dot[16] ? 17'(-ent_q.dot) : 17'(ent_q.dot);
		t_sign  = ent_q.w.sign ^ ent_q.a.sign ^ ent_q.dot[16];
		t_zero  = ent_q.w.zero || ent_q.a.zero || (ent_q.dot == '0);
		t_inf   = ent_q.w.inf || ent_q.a.inf;
		t_nan   = ent_q.w.nan || ent_q.a.nan || (t_inf && t_zero);
	end

	// Rounding of the exact product to binary32.
	logic [5:0]        t_lz;
	logic [37:0]       t_n;
	logic signed [9:0] t_be;
	logic              t_up;
	logic [31:0]       t_bits;
	always_comb begin
		t_lz   = lzc38(p_q);
		t_n    = p_q << t_lz;
		t_be   = 10'sd164 + 10'(exp_q) - $signed({4'b0000, t_lz});
		t_up   = t_n[13] && ((|t_n[12:0]) || t_n[14]);
		t_bits = {sign_q, 31'({t_be[7:0], t_n[36:14]}) + 31'(t_up)};
	end

	// Alignment of accumulator and term.
	logic        a_nan, b_nan, a_inf, b_inf, swap;
	logic [31:0] x, y;
	logic [7:0]  ex, ey, d;
	logic [26:0] my_ext, my_sh, my_lost;
	always_comb begin
		a_nan = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != '0);
		b_nan = (term_q[30:23] == 8'hFF) && (term_q[22:0] != '0);
		a_inf = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] == '0);
		b_inf = (term_q[30:23] == 8'hFF) && (term_q[22:0] == '0);
		swap  = term_q[30:0] > acc_q[30:0];
		x     = swap ? term_q : acc_q;
		y     = swap ? acc_q : term_q;
		ex    = (x[30:23] == '0) ? 8'd1 : x[30:23];
		ey    = (y[30:23] == '0) ? 8'd1 : y[30:23];
		d     = ex - ey;
		my_ext = {y[30:23] != '0, y[22:0], 3'b000};
		if (d >= 8'd27) begin
			my_sh   = '0;
			my_lost = my_ext;
		end else begin
			my_sh   = my_ext >> d[4:0];
			my_lost = my_ext & ~({27{1'b1}} << d[4:0]);
		end
	end

	// Add, normalise and round.
	logic [27:0] sum;
	logic [4:0]  s_lz;
	logic [7:0]  s_sh, s_lim;
	logic [26:0] s_n;
	logic [8:0]  s_e;
	logic [7:0]  s_field;
	logic        s_up;
	logic [31:0] add_res;
	always_comb begin
		sum   = aln_sub_q ? ({1'b0, aln_mx_q} - {1'b0, aln_my_q})
		                  : ({1'b0, aln_mx_q} + {1'b0, aln_my_q});
		s_lz  = lzc27(sum[26:0]);
		s_lim = aln_ex_q - 8'd1;
		s_sh  = ({3'b000, s_lz} < s_lim) ? {3'b000, s_lz} : s_lim;
		if (sum[27]) begin
			s_n = {sum[27:2], sum[1] | sum[0]};
			s_e = {1'b0, aln_ex_q} + 9'd1;
		end else begin
			s_n = sum[26:0] << s_sh;
			s_e = {1'b0, aln_ex_q} - {1'b0, s_sh};
		end
		s_field = s_n[26] ? s_e[7:0] : 8'd0;
		s_up    = s_n[2] && (s_n[1] || s_n[0] || s_n[3]);
		if (aln_spec_q) begin
			add_res = aln_spec_bits_q;
		end else if (sum == '0) begin
			add_res = aln_sub_q ? 32'd0 : {aln_sx_q, 31'd0};
		end else if (s_e >= 9'd255) begin
			add_res = {aln_sx_q, 8'hFF, 23'd0};
		end else begin
			add_res = {aln_sx_q, 31'({s_field, s_n[25:3]}) + 31'(s_up)};
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
		end
		if (state_q == q4q8_pkg::S_MUL1) begin
			pm_q    <= 22'(ent_q.w.mant) * 22'(ent_q.a.mant);
			mag_q   <= dot_abs[15:0];
			exp_q   <= 8'(ent_q.w.expo) + 8'(ent_q.a.expo);
			sign_q  <= t_sign;
			tspec_q <= t_nan || t_inf || t_zero;
			if (t_nan) begin
				tspec_bits_q <= q4q8_pkg::CanonNan;
			end else if (t_inf) begin
				tspec_bits_q <= {t_sign, 8'hFF, 23'd0};
			end else begin
				tspec_bits_q <= {t_sign, 31'd0};
			end
		end
		if (state_q == q4q8_pkg::S_MUL2) begin
			p_q <= 38'(pm_q) * 38'(mag_q);
		end
		if (state_q == q4q8_pkg::S_RND) begin
			term_q <= tspec_q ? tspec_bits_q : t_bits;
		end
		if (state_q == q4q8_pkg::S_ALN) begin
			aln_sx_q   <= x[31];
			aln_sub_q  <= x[31] ^ y[31];
			aln_ex_q   <= ex;
			aln_mx_q   <= {x[30:23] != '0, x[22:0], 3'b000};
			aln_my_q   <= {my_sh[26:1], my_sh[0] | (|my_lost)};
			aln_spec_q <= a_nan || b_nan || a_inf || b_inf;
			if (a_nan || b_nan || (a_inf && b_inf && (acc_q[31] != term_q[31]))) begin
				aln_spec_bits_q <= q4q8_pkg::CanonNan;
			end else begin
				aln_spec_bits_q <= a_inf ? acc_q : term_q;
			end
		end
		if (commit && ent_q.last) begin
			res_q <= add_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= q4q8_pkg::S_IDLE;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				acc_q <= ent_q.last ? 32'd0 : add_res;
			end
			if (commit && ent_q.last) begin
				res_valid_q <= 1'b1;
			end else if (!dot_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == q4q8_pkg::S_MUL1)
		else $error("request taken from the queue without starting work");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == q4q8_pkg::S_IDLE || state_q == q4q8_pkg::S_ADD))
		else $error("queue popped in the middle of a request");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && ent_q.last) |=> acc_q == 32'd0)
		else $error("accumulator not cleared after the last block");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && dot_stall) |=> res_valid_q && $stable(res_q))
		else $error("pending result lost while the receiver stalled");

	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !((res_q[30:23] == 8'hFF) && (res_q[22:0] != '0)
			&& (res_q != q4q8_pkg::CanonNan)))
		else $error("non-canonical NaN on the result");

endmodule

`default_nettype wire

[rtl/q4_q8_block_dot_product.sv]
// ============================================================================
// q4_q8_block_dot_product - Q4_0 x Q8_0 block dot product, fp32 accumulate
// Top level: request front end, decoupling queue and scaling/accumulate back.
// ============================================================================
// Each request on the blk channel carries one 32-value block pair: sixteen
// weight code bytes with an fp16 scale and thirty-two int8 activations with
// an fp16 scale. The front end forms the exact integer dot product and
// decodes both scales in the cycle the request is taken, then writes it to a
// short queue. blk_stall rises only when that queue is full.
// The back end takes one request at a time and steps it through S_MUL1 and
// S_MUL2 of the multiplier, S_RND for rounding and S_ALN and S_ADD of the
// fp32 adder. The adder closes the loop through the accumulator, so a new
// request is taken only when the previous one commits in S_ADD.
// A request with last_block set produces one result on the dot channel, the
// binary32 accumulator, which then returns to +0. The result is registered
// when that request commits in S_ADD. A result held by dot_stall stays put;
// the back end can still finish non-final requests, and the queue keeps
// accepting until it fills.
// Reset clears the accumulator to +0, empties the queue and drops dot_valid.
// ============================================================================
`default_nettype none

module q4_q8_block_dot_product #(
	parameter int QueueDepth = q4q8_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        blk_valid,
	output logic             blk_stall,
	input  wire logic [63:0] weight_bytes_low,
	input  wire logic [63:0] weight_bytes_high,
	input  wire logic [15:0] weight_scale,
	input  wire logic [63:0] act_values_0_7,
	input  wire logic [63:0] act_values_8_15,
	input  wire logic [63:0] act_values_16_23,
	input  wire logic [63:0] act_values_24_31,
	input  wire logic [15:0] act_scale,
	input  wire logic        last_block,
	output logic             dot_valid,
	input  wire logic        dot_stall,
	output logic [31:0]      dot_result
);

	q4q8_pkg::blk_entry_t front_entry;
	q4q8_pkg::blk_entry_t queue_entry;
	logic q_full, q_valid, q_pop;

	// Classification of each request.
	q4q8_front u_front (
		.weight_bytes_low  (weight_bytes_low),
		.weight_bytes_high (weight_bytes_high),
		.weight_scale      (weight_scale),
		.act_values_0_7    (act_values_0_7),
		.act_values_8_15   (act_values_8_15),
		.act_values_16_23  (act_values_16_23),
		.act_values_24_31  (act_values_24_31),
		.act_scale         (act_scale),
		.last_block        (last_block),
		.entry             (front_entry)
	);

	// The input side stalls only on a full queue.
	assign blk_stall = q_full;

	q4q8_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (blk_valid && !q_full),
		.wdata  (front_entry),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (queue_entry),
		.pop    (q_pop)
	);

	// Scaling, rounding and accumulation, with the result register.
	q4q8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (queue_entry),
		.q_pop      (q_pop),
		.dot_valid  (dot_valid),
		.dot_stall  (dot_stall),
		.dot_result (dot_result)
	);

endmodule

`default_nettype wire
